>>> rtl/tgc_pkg.sv
package tgc_pkg;

    localparam int unsigned NOW_W   = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned GEST_W  = 3;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned CIDX_W  = 3;

    typedef logic [NOW_W-1:0]   stamp_t;
    typedef logic [CFG_W-1:0]   cfg_val_t;
    typedef logic [GEST_W-1:0]  gesture_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [CIDX_W-1:0]  cfg_idx_t;

    // Item opcodes.
    localparam logic OP_TOUCH = 1'b0;
    localparam logic OP_POLL  = 1'b1;

    // Gesture codes.
    localparam gesture_t GST_NONE   = 3'd0;
    localparam gesture_t GST_SINGLE = 3'd1;
    localparam gesture_t GST_DOUBLE = 3'd2;
    localparam gesture_t GST_TRIPLE = 3'd3;
    localparam gesture_t GST_MORE   = 3'd4;
    localparam gesture_t GST_PRESS  = 3'd5;
    localparam gesture_t GST_HOLD   = 3'd6;
    localparam gesture_t GST_RESET  = 3'd7;

    // Register indexes.
    localparam cfg_idx_t REG_DEBOUNCE = 3'd0;
    localparam cfg_idx_t REG_TIMEOUT  = 3'd1;
    localparam cfg_idx_t REG_PRESS    = 3'd2;
    localparam cfg_idx_t REG_HOLD     = 3'd3;
    localparam cfg_idx_t REG_RESET    = 3'd4;

    // Register reset values.
    localparam cfg_val_t DEBOUNCE_RST = 16'd50;
    localparam cfg_val_t TIMEOUT_RST  = 16'd500;
    localparam cfg_val_t PRESS_RST    = 16'd300;
    localparam cfg_val_t HOLD_RST     = 16'd1500;
    localparam cfg_val_t RESET_RST    = 16'd5000;

    localparam count_t COUNT_MAX = 4'd15;

endpackage

>>> rtl/tgc_if.sv
interface tgc_item_if import tgc_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   opcode;
    stamp_t now_ms;

    modport source (output valid, output opcode, output now_ms, input ready);
    modport sink   (input valid, input opcode, input now_ms, output ready);
endinterface

interface tgc_result_if import tgc_pkg::*; ();
    logic     valid;
    logic     ready;
    gesture_t gesture;

    modport source (output valid, output gesture, input ready);
    modport sink   (input valid, input gesture, output ready);
endinterface

interface tgc_cfg_if import tgc_pkg::*; ();
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    cfg_val_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/touch_gesture_classifier.sv
// Touch gesture classifier: counts debounced touch requests and, on a poll request that
// follows a long enough silence, reports single, double, triple or more clicks, or a press,
// hold or reset by how long the gesture lasted. Every request on the item channel yields
// exactly one result request; touches always report "none". The block takes one request
// per clock cycle while the result register is not stalled, and passes it through the input
// register and then compare-and-subtract logic that updates the click state and loads
// the result register. The click state feeds back through that same logic, so adjacent
// requests never wait on each other. A stalled result register holds the input register,
// which then holds the item channel. Configuration writes are accepted in every cycle and
// take effect at once; they are meant to be made only while no request is in flight.
module touch_gesture_classifier import tgc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    tgc_item_if.sink           item,
    tgc_result_if.source       result,
    tgc_cfg_if.sink            cfg
);

    // Configuration registers.
    cfg_val_t debounce_reg;
    cfg_val_t timeout_reg;
    cfg_val_t press_reg;
    cfg_val_t hold_reg;
    cfg_val_t reset_ms_reg;

    // Gesture state.
    count_t count_reg;
    count_t count_next;
    stamp_t start_reg;
    stamp_t start_next;
    stamp_t last_reg;
    stamp_t last_next;

    // Input stage.
    logic   in_valid_reg;
    logic   in_op_reg;
    stamp_t in_now_reg;

    // Result stage.
    logic     out_valid_reg;
    gesture_t out_gest_reg;
    gesture_t gest_next;

    logic   in_fire;
    logic   stage_fire;
    logic   out_free;
    stamp_t since_last;
    stamp_t duration;
    logic   classify;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            timeout_reg  <= TIMEOUT_RST;
            press_reg    <= PRESS_RST;
            hold_reg     <= HOLD_RST;
            reset_ms_reg <= RESET_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DEBOUNCE: debounce_reg <= cfg.data;
                REG_TIMEOUT:  timeout_reg  <= cfg.data;
                REG_PRESS:    press_reg    <= cfg.data;
                REG_HOLD:     hold_reg     <= cfg.data;
                REG_RESET:    reset_ms_reg <= cfg.data;
                default:      ;
            endcase
        end
    end

    // The result register frees up when empty or when its result is taken this cycle.
    assign out_free   = !out_valid_reg || result.ready;
    assign stage_fire = in_valid_reg && out_free;
    assign item.ready = !in_valid_reg || out_free;
    assign in_fire    = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_op_reg  <= item.opcode;
            in_now_reg <= item.now_ms;
        end
    end

    // Timestamp differences wrap modulo 2^32, which plain unsigned subtraction gives.
    assign since_last = in_now_reg - last_reg;
    assign duration   = in_now_reg - start_reg;
    assign classify   = (count_reg != '0) && (since_last > {{(NOW_W-CFG_W){1'b0}}, timeout_reg});

    always_comb
    begin
        count_next = count_reg;
        start_next = start_reg;
        last_next  = last_reg;
        gest_next  = GST_NONE;
        if (in_op_reg == OP_TOUCH)
        begin
            // A touch no farther than the debounce gap from the last accepted one is a bounce.
            if (since_last > {{(NOW_W-CFG_W){1'b0}}, debounce_reg})
            begin
                last_next = in_now_reg;
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + count_t'(1);
                end
            end
            // The gesture start follows every touch while the count stands at one,
            // bounces included.
            if (count_next == count_t'(1))
            begin
                start_next = in_now_reg;
            end
        end
        else if (classify)
        begin
            // Duration thresholds are checked longest first, whatever their values.
            if (duration > {{(NOW_W-CFG_W){1'b0}}, reset_ms_reg})
            begin
                gest_next = GST_RESET;
            end
            else if (duration > {{(NOW_W-CFG_W){1'b0}}, hold_reg})
            begin
                gest_next = GST_HOLD;
            end
            else if (duration > {{(NOW_W-CFG_W){1'b0}}, press_reg})
            begin
                gest_next = GST_PRESS;
            end
            else if (count_reg <= count_t'(GST_TRIPLE))
            begin
                gest_next = gesture_t'(count_reg);
            end
            else
            begin
                gest_next = GST_MORE;
            end
            count_next = '0;
            start_next = in_now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            start_reg <= '0;
            last_reg  <= '0;
        end
        else if (stage_fire)
        begin
            count_reg <= count_next;
            start_reg <= start_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire)
        begin
            out_gest_reg <= gest_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.gesture = out_gest_reg;

`ifndef ASSERT_OFF
    // A touch never reports a gesture.
    a_touch_none: assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire && (in_op_reg == OP_TOUCH) |=> (out_gest_reg == GST_NONE))
        else $error("touch produced a gesture");

    // A reported gesture clears the click count.
    a_gesture_clears: assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire && (in_op_reg == OP_POLL) && (gest_next != GST_NONE)
        |=> (count_reg == '0))
        else $error("click count not cleared after a gesture");

    // A gesture is only ever reported with clicks pending.
    a_gesture_needs_clicks: assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire && (gest_next != GST_NONE) |-> (count_reg != '0))
        else $error("gesture reported with no clicks");

    // A touch that leaves the count at one stamps the gesture start.
    a_start_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire && (in_op_reg == OP_TOUCH) && (count_next == count_t'(1))
        |=> (start_reg == $past(in_now_reg)))
        else $error("start stamp not taken from first click");

    // The item channel is open whenever the result register is empty.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> item.ready)
        else $error("item channel stalled with empty result register");
`endif

endmodule

>>> tb/tb_touch_gesture_classifier.sv
module tb_touch_gesture_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import tgc_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 12;
    // Quiet cycles added once the block has delivered every expected gesture, before
    // any register write or the end of the run.
    localparam int SETTLE_CYCLES  = 4;
    // Cycles without any handshake on any channel before the run is abandoned.
    localparam int STALL_LIMIT    = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 255;
    localparam int CLEAN_ITEMS    = 200;
    localparam cfg_idx_t LAST_IDX = '1;

    // Flavors of register settings used by the random phases.
    typedef enum int {
        CFG_TYPICAL,
        CFG_WILD,
        CFG_TIGHT,
        CFG_RAILS
    } cfg_style_e;

    logic clk = 1'b0;
    logic rst_n;

    tgc_item_if   item_ch ();
    tgc_result_if result_ch ();
    tgc_cfg_if    cfg_ch ();

    touch_gesture_classifier dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    always #HALF_PERIOD clk = ~clk;

    // Shadow copy of the five limit registers, updated when a write is taken.
    cfg_val_t debounce_lim;
    cfg_val_t silence_lim;
    cfg_val_t press_lim;
    cfg_val_t hold_lim;
    cfg_val_t reset_lim;

    // Shadow copy of the click state that the block keeps.
    count_t clicks;
    stamp_t touch_start;
    stamp_t last_touch;

    // Gestures that the block owes us, oldest first.
    gesture_t pending_gestures[$];
    gesture_t want;

    int fail_count    = 0;
    int items_sent    = 0;
    int settings_made = 0;
    int gesture_seen[8];

    // Timeline that the stimulus walks along.
    stamp_t t_now;

    // Idling controls for the two sides of the item path.
    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    int stall_left = 0;

    // Works out the gesture that one request yields and advances the shadow state
    // exactly as the block would. A touch never reports anything; a poll reports
    // only when clicks are pending and the pad has been quiet longer than the
    // timeout, and then it starts a fresh gesture at the poll's own timestamp.
    function automatic gesture_t classify_request(logic op, stamp_t now);
        stamp_t   since_touch;
        stamp_t   held;
        gesture_t g;

        g = GST_NONE;
        since_touch = now - last_touch;
        if (op == OP_TOUCH) begin
            if (since_touch > stamp_t'(debounce_lim)) begin
                last_touch = now;
                if (clicks != COUNT_MAX)
                    clicks = clicks + 1'b1;
            end
            // Bounced touches also move the start while the count sits at one.
            if (clicks == count_t'(1))
                touch_start = now;
        end else if (clicks != '0 && since_touch > stamp_t'(silence_lim)) begin
            held = now - touch_start;
            // Duration thresholds are checked from the longest name down,
            // regardless of how the registers actually relate to each other.
            if (held > stamp_t'(reset_lim))
                g = GST_RESET;
            else if (held > stamp_t'(hold_lim))
                g = GST_HOLD;
            else if (held > stamp_t'(press_lim))
                g = GST_PRESS;
            else begin
                case (clicks)
                    count_t'(1): g = GST_SINGLE;
                    count_t'(2): g = GST_DOUBLE;
                    count_t'(3): g = GST_TRIPLE;
                    default:     g = GST_MORE;
                endcase
            end
            clicks = '0;
            touch_start = now;
        end
        return g;
    endfunction

    // Presents one request on the item channel, with an occasional idle burst in
    // front of it, and records the expected gesture once the block takes it. The
    // valid line stays high afterwards so back-to-back requests need no bubble;
    // whoever does something else next lowers it.
    task automatic send_request(input logic op, input stamp_t now);
        logic taken;

        if (gaps_on && $urandom_range(0, 7) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.opcode <= op;
        item_ch.now_ms <= now;
        // Ready is looked at on the falling edge, where it is settled, and the
        // request counts as taken on the rising edge that follows.
        do begin
            @(negedge clk);
            taken = item_ch.ready;
            @(posedge clk);
        end while (!taken);
        pending_gestures.push_back(classify_request(op, now));
        items_sent++;
    endtask

    // Lets the block run dry: no new requests until every expected gesture has
    // been delivered, then waits out the quiet settle period on top.
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (pending_gestures.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register and mirrors it in the shadow copy. Indexes above the
    // last register are dropped by the block, so they leave the shadow alone.
    task automatic write_reg(input cfg_idx_t idx, input cfg_val_t val);
        logic taken;

        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do begin
            @(negedge clk);
            taken = cfg_ch.ready;
            @(posedge clk);
        end while (!taken);
        case (idx)
            REG_DEBOUNCE: debounce_lim = val;
            REG_TIMEOUT:  silence_lim  = val;
            REG_PRESS:    press_lim    = val;
            REG_HOLD:     hold_lim     = val;
            REG_RESET:    reset_lim    = val;
            default:      ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limits(input cfg_val_t deb, input cfg_val_t quiet, input cfg_val_t prs,
                              input cfg_val_t hld, input cfg_val_t rst);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_TIMEOUT, quiet);
        write_reg(REG_PRESS, prs);
        write_reg(REG_HOLD, hld);
        write_reg(REG_RESET, rst);
        settings_made++;
    endtask

    // Picks a full register setting in the given style and writes it. The
    // typical style keeps the thresholds ordered so every gesture kind shows up;
    // the others mix them freely, including both rails.
    task automatic apply_random_limits(input cfg_style_e style);
        cfg_val_t v[5];

        case (style)
            CFG_TYPICAL: begin
                v[0] = cfg_val_t'($urandom_range(0, 80));
                v[1] = cfg_val_t'($urandom_range(20, 300));
                v[2] = v[1] + cfg_val_t'($urandom_range(50, 500));
                v[3] = v[2] + cfg_val_t'($urandom_range(1, 2000));
                v[4] = v[3] + cfg_val_t'($urandom_range(1, 5000));
            end
            CFG_WILD: begin
                foreach (v[i])
                    v[i] = cfg_val_t'($urandom_range(0, 16'hFFFF));
            end
            CFG_TIGHT: begin
                foreach (v[i])
                    v[i] = cfg_val_t'($urandom_range(0, 1500));
            end
            default: begin
                foreach (v[i])
                    v[i] = $urandom_range(0, 1) ? '1 : '0;
            end
        endcase
        set_limits(v[0], v[1], v[2], v[3], v[4]);
        if ($urandom_range(0, 3) == 0)
            write_reg(cfg_idx_t'($urandom_range(REG_RESET + 1, LAST_IDX)),
                      cfg_val_t'($urandom()));
    endtask

    // One well-formed gesture: a run of touches, some of them bounces, maybe an
    // early poll within the timeout of the latest touch, then a poll placed after the
    // timeout so that the duration lands near one of the thresholds.
    task automatic play_gesture();
        int     n;
        stamp_t gap;
        stamp_t dur;
        stamp_t by_silence;
        stamp_t by_duration;

        n = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(0, 4) == 0)
                gap = $urandom_range(0, debounce_lim);
            else
                gap = stamp_t'(debounce_lim) + 1 + $urandom_range(0, 150);
            t_now = t_now + gap;
            send_request(OP_TOUCH, t_now);
            if ($urandom_range(0, 5) == 0)
                send_request(OP_POLL, t_now + $urandom_range(0, silence_lim));
        end
        // Now and then the gesture is left open for the next one to absorb.
        if ($urandom_range(0, 9) == 0)
            return;
        case ($urandom_range(0, 3))
            0:       dur = stamp_t'(press_lim);
            1:       dur = stamp_t'(hold_lim);
            2:       dur = stamp_t'(reset_lim);
            default: dur = '0;
        endcase
        dur = dur + $urandom_range(0, 4);
        if (dur >= 2)
            dur = dur - 2;
        by_duration = touch_start + dur;
        by_silence  = last_touch + stamp_t'(silence_lim) + 1 + $urandom_range(0, 3);
        if ($signed(by_duration - last_touch) > $signed(stamp_t'(silence_lim)))
            t_now = by_duration;
        else
            t_now = by_silence;
        send_request(OP_POLL, t_now);
    endtask

    // A stray request: either opcode, near the timeline or anywhere at all.
    task automatic send_noise();
        logic   op;
        stamp_t now;

        op  = $urandom_range(0, 1) ? OP_POLL : OP_TOUCH;
        now = $urandom_range(0, 1) ? stamp_t'($urandom()) : t_now + $urandom_range(0, 3000);
        t_now = now;
        send_request(op, now);
    endtask

    // Reset values of the registers, an empty poll, a touch far from the zero
    // stamp, and a press measured across the wrap of the millisecond counter.
    task automatic test_after_reset();
        send_request(OP_POLL, 32'h0000_0000);
        send_request(OP_TOUCH, 32'hFFFF_FFFF);
        send_request(OP_POLL, 32'h0000_0100);
        send_request(OP_POLL, 32'h0000_01F4);
        t_now = 32'h0000_01F4;
    endtask

    // Single, double and more clicks under short thresholds. The double click has
    // a bounce in it that moves the start while the count is still one. A write
    // to an index past the last register must change nothing.
    task automatic test_click_counts();
        stamp_t base;

        drain();
        set_limits(16'd20, 16'd200, 16'd400, 16'd1000, 16'd3000);
        write_reg(cfg_idx_t'(REG_RESET + 1), 16'hFFFF);
        base = t_now + 1000;
        send_request(OP_TOUCH, base);
        send_request(OP_POLL, base + 250);
        base = base + 1000;
        send_request(OP_TOUCH, base);
        send_request(OP_TOUCH, base + 10);
        send_request(OP_TOUCH, base + 40);
        send_request(OP_POLL, base + 300);
        base = base + 1000;
        for (int i = 0; i < 4; i++)
            send_request(OP_TOUCH, base + 30 * i);
        send_request(OP_POLL, base + 300);
        t_now = base + 300;
    endtask

    // Long single touches that classify as hold and as reset.
    task automatic test_durations();
        t_now = t_now + 1000;
        send_request(OP_TOUCH, t_now);
        send_request(OP_POLL, t_now + 1200);
        t_now = t_now + 2000;
        send_request(OP_TOUCH, t_now);
        t_now = t_now + 3500;
        send_request(OP_POLL, t_now);
    endtask

    // All registers at zero, then all at full scale. At zero a touch at the same
    // millisecond is a bounce and a poll at that millisecond is not yet quiet; at
    // full scale the boundary of the timeout is hit exactly.
    task automatic test_register_extremes();
        drain();
        set_limits('0, '0, '0, '0, '0);
        t_now = t_now + 100;
        send_request(OP_TOUCH, t_now);
        send_request(OP_TOUCH, t_now);
        send_request(OP_POLL, t_now);
        send_request(OP_POLL, t_now + 1);
        drain();
        set_limits('1, '1, '1, '1, '1);
        t_now = t_now + 1 + 32'h0001_0000;
        send_request(OP_TOUCH, t_now);
        send_request(OP_POLL, t_now + 32'h0000_FFFF);
        send_request(OP_POLL, t_now + 32'h0001_0000);
        t_now = t_now + 32'h0001_0000;
    endtask

    // The bulk of the run: phases of random gestures and noise, each under its
    // own register setting. Every phase begins with a full drain, so the sender
    // repeatedly holds off until the block has nothing left to deliver.
    task automatic test_random_gestures();
        cfg_style_e style;
        int         phase_end;

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            case (p % 4)
                0:       style = CFG_TYPICAL;
                1:       style = CFG_TIGHT;
                2:       style = CFG_WILD;
                default: style = CFG_RAILS;
            endcase
            apply_random_limits(style);
            gaps_on   = 1'b1;
            stalls_on = (p != 3);
            // One phase starts just short of the wrap of the timestamp.
            t_now = (p == 1) ? 32'hFFFF_0000 : stamp_t'($urandom());
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 7) == 0)
                    send_noise();
                else
                    play_gesture();
            end
        end
    endtask

    // The last stretch runs at full rate with neither side idling.
    task automatic test_clean_stream();
        int stop_at;

        drain();
        apply_random_limits(CFG_TYPICAL);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        stop_at = items_sent + CLEAN_ITEMS;
        while (items_sent < stop_at)
            play_gesture();
    endtask

    // Result side: the ready line stalls in random bursts and
    // stays low while reset is held.
    always @(posedge clk) begin
        if (!rst_n) begin
            stall_left = 0;
            result_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            result_ch.ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 15);
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // Result checker. Valid and ready only move on the rising edge, so whatever
    // holds on the falling edge is what the next rising edge accepts.
    always @(negedge clk) begin
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_gestures.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result, gesture %0d", $realtime,
                             result_ch.gesture);
            end else begin
                want = pending_gestures.pop_front();
                if (result_ch.gesture !== want) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: gesture expected %0d, got %0d", $realtime, want,
                                 result_ch.gesture);
                end else begin
                    gesture_seen[want]++;
                end
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    initial begin
        int quiet;

        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(negedge clk);
            if (!rst_n || (item_ch.valid && item_ch.ready) ||
                (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("No progress for %0d cycles.", STALL_LIMIT);
        $display("touch_gesture_classifier: mismatch");
        $finish;
    end

    initial begin
        // Everything the block sees is known from time zero; reset is held for a
        // while and then released once, never to come back.
        rst_n            <= 1'b0;
        item_ch.valid    <= 1'b0;
        item_ch.opcode   <= OP_TOUCH;
        item_ch.now_ms   <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_DEBOUNCE;
        cfg_ch.data      <= '0;
        debounce_lim = DEBOUNCE_RST;
        silence_lim  = TIMEOUT_RST;
        press_lim    = PRESS_RST;
        hold_lim     = HOLD_RST;
        reset_lim    = RESET_RST;
        clicks       = '0;
        touch_start  = '0;
        last_touch   = '0;
        t_now        = '0;
        foreach (gesture_seen[i])
            gesture_seen[i] = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_click_counts();
        test_durations();
        test_register_extremes();
        test_random_gestures();
        test_clean_stream();
        drain();

        $display("Ran %0d requests under %0d register settings; failures: %0d.",
                 items_sent, settings_made, fail_count);
        $display({"Gestures seen: none %0d, 1x %0d, 2x %0d, 3x %0d, more %0d, ",
                  "press %0d, hold %0d, reset %0d."},
                 gesture_seen[GST_NONE], gesture_seen[GST_SINGLE], gesture_seen[GST_DOUBLE],
                 gesture_seen[GST_TRIPLE], gesture_seen[GST_MORE], gesture_seen[GST_PRESS],
                 gesture_seen[GST_HOLD], gesture_seen[GST_RESET]);
        if (fail_count == 0 && pending_gestures.size() == 0)
            $display("touch_gesture_classifier: match");
        else
            $display("touch_gesture_classifier: mismatch");
        $finish;
    end

endmodule
